// ----- rtl/core/ppgest_pkg.sv -----
// Shared types, widths and constants for the heart-rate and SpO2 estimator.
// No dependencies; every other file in rtl/core imports this package.
package ppgest_pkg;

   localparam int SMOOTH_WINDOW = 8;
   localparam int HISTORY_DEPTH = 8;

   localparam int SAMPLE_W  = 18;
   localparam int TICK_W    = 32;
   localparam int DC_W      = 34;
   localparam int DC_FRAC   = 16;
   localparam int ALPHA_W   = 16;
   localparam int PERIOD_W  = 10;
   localparam int IVL_W     = 16;
   localparam int HR_W      = 8;
   localparam int SPO2_W    = 7;
   localparam int STATUS_W  = 2;

   localparam int WIN_IDX_W = (SMOOTH_WINDOW > 1) ? $clog2(SMOOTH_WINDOW) : 1;
   localparam int WIN_CNT_W = $clog2(SMOOTH_WINDOW + 1);
   localparam int WIN_SUM_W = SAMPLE_W + $clog2(SMOOTH_WINDOW);

   localparam int HIST_IDX_W = $clog2(HISTORY_DEPTH);
   localparam int HIST_CNT_W = $clog2(HISTORY_DEPTH + 1);
   localparam int HIST_SUM_W = HR_W + HIST_CNT_W;

   localparam int DIV_N_W   = 40;
   localparam int DIV_D_W   = 34;
   localparam int DIV_CNT_W = 6;

   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 17;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;
   localparam int SP_W    = 39;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 18;

   localparam logic [CSR_IDX_W-1:0] CSR_PRESENCE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHA      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TICK_MS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_IVL    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_IVL    = 3'd5;

   localparam logic [SAMPLE_W-1:0] RST_PRESENCE   = 18'd10000;
   localparam logic [SAMPLE_W-1:0] RST_MIN_HEIGHT = 18'd100;
   localparam logic [ALPHA_W-1:0]  RST_ALPHA      = 16'd62259;
   localparam logic [PERIOD_W-1:0] RST_TICK_MS    = 10'd1;
   localparam logic [IVL_W-1:0]    RST_MIN_IVL    = 16'd350;
   localparam logic [IVL_W-1:0]    RST_MAX_IVL    = 16'd1500;

   localparam logic [STATUS_W-1:0] STATUS_IDLE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SAMPLING = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd2;

   localparam logic [MUL_B_W-1:0] DC_ONE   = 17'h10000;
   localparam logic [ACC_W-1:0]   DC_ROUND = 52'd32768;
   localparam logic [DIV_N_W-1:0] BPM_NUM  = 40'd60000;
   localparam logic [HR_W-1:0]    BPM_MAX  = 8'd255;
   localparam logic [5:0]         SPO2_FULL_C = 6'd10;
   localparam logic [SPO2_W-1:0]  SPO2_BASE   = 7'd110;
   localparam logic [SPO2_W-1:0]  SPO2_MAX    = 7'd100;

   typedef enum logic [4:0] {
      OP_NONE, OP_CLEAR, OP_WRITE, OP_SUM, OP_DIV_IR, OP_TAKE_IR, OP_DIV_RED,
      OP_TAKE_RED, OP_SEED, OP_MUL_IR_OLD, OP_MUL_IR_NEW, OP_UPD_IR,
      OP_MUL_RED_NEW, OP_UPD_RED, OP_DETECT, OP_IVL, OP_DIV_BPM, OP_TAKE_BPM,
      OP_HSUM, OP_DIV_HR, OP_TAKE_HR, OP_SPMUL, OP_SP_ZERO, OP_DIV_SP,
      OP_TAKE_SP, OP_VALID, OP_FINISH, OP_PUBLISH
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic below_thr;
      logic div_busy;
      logic dc_zero;
      logic beat;
      logic ivl_ok;
      logic hist_ok;
      logic spo2_en;
      logic spo2_over;
      logic rsp_free;
   } stat_type;

   typedef struct packed {
      logic [SAMPLE_W-1:0] presence;
      logic [SAMPLE_W-1:0] min_height;
      logic [ALPHA_W-1:0]  alpha;
      logic [PERIOD_W-1:0] tick_ms;
      logic [IVL_W-1:0]    min_ivl;
      logic [IVL_W-1:0]    max_ivl;
   } cfg_type;

endpackage

// ----- rtl/core/pulse_oximeter_hr_spo2_estimator_unit.sv -----
// Heart-rate and SpO2 estimator, top level: register file, controller, datapath.
// One sample at a time; the next sample is taken once the result of the last one has
// been published. A sample with a finger present runs two window-mean divides on the
// shared one-bit-per-cycle divider; a scored beat adds up to three (rate, mean, SpO2).
// Synchronous reset clears all estimator state and loads register defaults.
module pulse_oximeter_hr_spo2_estimator_unit import ppgest_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [SAMPLE_W-1:0]   req_ir_sample,
   input  logic [SAMPLE_W-1:0]   req_red_sample,
   input  logic [TICK_W-1:0]     req_tick_now,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [HR_W-1:0]       rsp_heart_rate,
   output logic [SPO2_W-1:0]     rsp_spo2_percent,
   output logic                  rsp_reading_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff;
   cmd_type  cmd;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.presence   <= RST_PRESENCE;
         cfg_ff.min_height <= RST_MIN_HEIGHT;
         cfg_ff.alpha      <= RST_ALPHA;
         cfg_ff.tick_ms    <= RST_TICK_MS;
         cfg_ff.min_ivl    <= RST_MIN_IVL;
         cfg_ff.max_ivl    <= RST_MAX_IVL;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_PRESENCE:   cfg_ff.presence   <= csr_data;
            CSR_MIN_HEIGHT: cfg_ff.min_height <= csr_data;
            CSR_ALPHA:      cfg_ff.alpha      <= csr_data[ALPHA_W-1:0];
            CSR_TICK_MS:    cfg_ff.tick_ms    <= csr_data[PERIOD_W-1:0];
            CSR_MIN_IVL:    cfg_ff.min_ivl    <= csr_data[IVL_W-1:0];
            CSR_MAX_IVL:    cfg_ff.max_ivl    <= csr_data[IVL_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   ppgest_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   ppgest_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg_ff),
      .cmd               (cmd),
      .stat              (stat),
      .req_fire          (req_valid && req_ready),
      .req_ir_sample     (req_ir_sample),
      .req_red_sample    (req_red_sample),
      .req_tick_now      (req_tick_now),
      .rsp_ready         (rsp_ready),
      .rsp_valid         (rsp_valid),
      .rsp_heart_rate    (rsp_heart_rate),
      .rsp_spo2_percent  (rsp_spo2_percent),
      .rsp_reading_valid (rsp_reading_valid),
      .rsp_status        (rsp_status)
   );

endmodule

// ----- rtl/core/ppgest_div.sv -----
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on ppgest_pkg for widths.
module ppgest_div import ppgest_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_N_W-1:0]   dividend,
   input  logic [DIV_D_W-1:0]   divisor,
   input  logic [DIV_CNT_W-1:0] bits,
   output logic                 busy,
   output logic [DIV_N_W-1:0]   quotient
);

   logic [DIV_N_W-1:0]   quo_ff;
   logic [DIV_D_W-1:0]   rem_ff, dvs_ff, rem_in;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [DIV_D_W:0]     trial;
   logic                 fits;

   assign trial  = {rem_ff, quo_ff[DIV_N_W-1]};
   assign fits   = trial >= {1'b0, dvs_ff};
   assign rem_in = fits ? DIV_D_W'(trial - {1'b0, dvs_ff}) : trial[DIV_D_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (start) begin
         cnt_ff <= bits;
      end else if (cnt_ff != '0) begin
         cnt_ff <= cnt_ff - DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // left-align the dividend so only the requested bits are walked
         quo_ff <= dividend << (DIV_CNT_W'(DIV_N_W) - bits);
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cnt_ff != '0) begin
         quo_ff <= {quo_ff[DIV_N_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign busy     = cnt_ff != '0;
   assign quotient = quo_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy)
      else $error("divider restarted while busy");

endmodule

// ----- rtl/core/ppgest_dp.sv -----
// Datapath: sample windows, DC averages, beat detector, rate history, SpO2
// and the result register. Depends on ppgest_pkg and ppgest_div.
module ppgest_dp import ppgest_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  cfg_type             cfg,
   input  cmd_type             cmd,
   output stat_type            stat,
   input  logic                req_fire,
   input  logic [SAMPLE_W-1:0] req_ir_sample,
   input  logic [SAMPLE_W-1:0] req_red_sample,
   input  logic [TICK_W-1:0]   req_tick_now,
   input  logic                rsp_ready,
   output logic                rsp_valid,
   output logic [HR_W-1:0]     rsp_heart_rate,
   output logic [SPO2_W-1:0]   rsp_spo2_percent,
   output logic                rsp_reading_valid,
   output logic [STATUS_W-1:0] rsp_status
);

   // sample and scratch registers
   logic [SAMPLE_W-1:0]   ir_ff, red_ff, ir_s_ff, red_s_ff;
   logic [TICK_W-1:0]     now_ff;
   logic [WIN_SUM_W-1:0]  ir_sum_ff, red_sum_ff, ir_sum_in, red_sum_in;
   logic [WIN_CNT_W-1:0]  win_cnt_ff, win_cnt_in;
   logic [PROD_W-1:0]     prod_ff, prod_in;
   logic [ACC_W-1:0]      acc_ff, upd_sum;
   logic                  is_peak_ff, is_trough_ff, beat_ff;
   logic [HIST_SUM_W-1:0] hsum_ff, hsum_in;
   logic [HIST_CNT_W-1:0] hcnt_ff, hcnt_in;
   logic [SP_W-1:0]       num_ff, lim_ff;

   // estimator state
   logic [SAMPLE_W-1:0]   ir_win_ff  [SMOOTH_WINDOW];
   logic [SAMPLE_W-1:0]   red_win_ff [SMOOTH_WINDOW];
   logic [WIN_IDX_W-1:0]  win_pos_ff;
   logic                  win_full_ff;
   logic [SAMPLE_W-1:0]   prev_ff, prev2_ff, peak_level_ff, valley_level_ff;
   logic [DC_W-1:0]       dc_ir_ff, dc_red_ff;
   logic [TICK_W-1:0]     last_tick_ff;
   logic                  peak_seen_ff, rising_ff;
   logic [HR_W-1:0]       hist_ff [HISTORY_DEPTH];
   logic [HIST_IDX_W-1:0] hist_pos_ff;
   logic [HR_W-1:0]       held_hr_ff;
   logic [SPO2_W-1:0]     held_spo2_ff;
   logic                  held_valid_ff, finger_ff;

   logic                  rsp_valid_ff, rsp_rv_ff;
   logic [HR_W-1:0]       rsp_hr_ff;
   logic [SPO2_W-1:0]     rsp_spo2_ff;
   logic [STATUS_W-1:0]   rsp_status_ff;

   logic [MUL_A_W-1:0]    mul_a;
   logic [MUL_B_W-1:0]    mul_b, alpha_rest;
   logic [TICK_W-1:0]     tick_diff;
   logic                  det_en, is_peak, is_trough, amp_ok;
   logic [HR_W-1:0]       bpm_sat;
   logic [5:0]            sp_c;
   logic [SPO2_W-1:0]     sp_take;

   logic                  div_start, div_busy;
   logic [DIV_N_W-1:0]    div_n, div_q;
   logic [DIV_D_W-1:0]    div_d;
   logic [DIV_CNT_W-1:0]  div_bits;

   // window sums: slots never written since the last clear hold zero
   always_comb begin
      ir_sum_in  = '0;
      red_sum_in = '0;
      for (int i = 0; i < SMOOTH_WINDOW; i++) begin
         ir_sum_in  = ir_sum_in + WIN_SUM_W'(ir_win_ff[i]);
         red_sum_in = red_sum_in + WIN_SUM_W'(red_win_ff[i]);
      end
   end

   assign win_cnt_in = win_full_ff ? WIN_CNT_W'(SMOOTH_WINDOW)
                                   : WIN_CNT_W'(win_pos_ff) + WIN_CNT_W'(1);

   always_comb begin
      hsum_in = '0;
      hcnt_in = '0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         if (hist_ff[i] != '0) begin
            hsum_in = hsum_in + HIST_SUM_W'(hist_ff[i]);
            hcnt_in = hcnt_in + HIST_CNT_W'(1);
         end
      end
   end

   assign det_en    = win_full_ff && (prev2_ff != '0);
   assign is_peak   = (prev_ff > prev2_ff) && (prev_ff > ir_s_ff);
   assign is_trough = (prev_ff < prev2_ff) && (prev_ff < ir_s_ff);
   assign amp_ok    = (prev_ff > valley_level_ff)
                      && ((prev_ff - valley_level_ff) > cfg.min_height);
   assign tick_diff = now_ff - last_tick_ff;

   assign alpha_rest = DC_ONE - MUL_B_W'(cfg.alpha);

   always_comb begin
      unique case (cmd.op)
         OP_MUL_IR_OLD: begin
            mul_a = MUL_A_W'(dc_ir_ff);
            mul_b = MUL_B_W'(cfg.alpha);
         end
         OP_MUL_IR_NEW: begin
            mul_a = MUL_A_W'(ir_s_ff);
            mul_b = alpha_rest;
         end
         OP_UPD_IR: begin
            mul_a = MUL_A_W'(dc_red_ff);
            mul_b = MUL_B_W'(cfg.alpha);
         end
         OP_MUL_RED_NEW: begin
            mul_a = MUL_A_W'(red_s_ff);
            mul_b = alpha_rest;
         end
         OP_IVL: begin
            mul_a = MUL_A_W'(tick_diff);
            mul_b = MUL_B_W'(cfg.tick_ms);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign upd_sum = acc_ff + (ACC_W'(prod_ff) << DC_FRAC);

   always_comb begin
      unique case (cmd.op)
         OP_DIV_IR: begin
            div_n    = DIV_N_W'(ir_sum_ff);
            div_d    = DIV_D_W'(win_cnt_ff);
            div_bits = DIV_CNT_W'(WIN_SUM_W);
         end
         OP_DIV_RED: begin
            div_n    = DIV_N_W'(red_sum_ff);
            div_d    = DIV_D_W'(win_cnt_ff);
            div_bits = DIV_CNT_W'(WIN_SUM_W);
         end
         OP_DIV_BPM: begin
            div_n    = BPM_NUM;
            div_d    = DIV_D_W'(prod_ff[IVL_W-1:0]);
            div_bits = DIV_CNT_W'(IVL_W);
         end
         OP_DIV_HR: begin
            div_n    = DIV_N_W'(hsum_ff);
            div_d    = DIV_D_W'(hcnt_ff);
            div_bits = DIV_CNT_W'(HIST_SUM_W);
         end
         OP_DIV_SP: begin
            // round the quotient up
            div_n    = DIV_N_W'(num_ff) + DIV_N_W'(dc_red_ff) - DIV_N_W'(1);
            div_d    = dc_red_ff;
            div_bits = DIV_CNT_W'(DIV_N_W);
         end
         default: begin
            div_n    = '0;
            div_d    = '0;
            div_bits = '0;
         end
      endcase
   end

   assign div_start = (cmd.op == OP_DIV_IR) || (cmd.op == OP_DIV_RED)
                      || (cmd.op == OP_DIV_BPM) || (cmd.op == OP_DIV_HR)
                      || (cmd.op == OP_DIV_SP);

   ppgest_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_n),
      .divisor  (div_d),
      .bits     (div_bits),
      .busy     (div_busy),
      .quotient (div_q)
   );

   assign bpm_sat = (div_q[DIV_N_W-1:HR_W] != '0) ? BPM_MAX : div_q[HR_W-1:0];
   assign sp_c    = div_q[5:0];
   assign sp_take = (sp_c <= SPO2_FULL_C) ? SPO2_MAX : SPO2_BASE - SPO2_W'(sp_c);

   // estimator state; a missing finger clears it like reset
   always_ff @(posedge clock) begin
      if (reset || (cmd.op == OP_CLEAR)) begin
         for (int i = 0; i < SMOOTH_WINDOW; i++) begin
            ir_win_ff[i]  <= '0;
            red_win_ff[i] <= '0;
         end
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
         win_pos_ff      <= '0;
         win_full_ff     <= 1'b0;
         prev_ff         <= '0;
         prev2_ff        <= '0;
         dc_ir_ff        <= '0;
         dc_red_ff       <= '0;
         peak_level_ff   <= '0;
         valley_level_ff <= '0;
         last_tick_ff    <= '0;
         peak_seen_ff    <= 1'b0;
         rising_ff       <= 1'b0;
         hist_pos_ff     <= '0;
         held_hr_ff      <= '0;
         held_spo2_ff    <= '0;
         held_valid_ff   <= 1'b0;
         finger_ff       <= 1'b0;
      end else begin
         case (cmd.op)
            OP_WRITE: begin
               ir_win_ff[win_pos_ff]  <= ir_ff;
               red_win_ff[win_pos_ff] <= red_ff;
               finger_ff              <= 1'b1;
            end
            OP_TAKE_RED: begin
               if (win_pos_ff == WIN_IDX_W'(SMOOTH_WINDOW - 1)) begin
                  win_pos_ff  <= '0;
                  win_full_ff <= 1'b1;
               end else begin
                  win_pos_ff <= win_pos_ff + WIN_IDX_W'(1);
               end
            end
            OP_SEED: begin
               dc_ir_ff  <= DC_W'({ir_s_ff, DC_FRAC'(0)});
               dc_red_ff <= DC_W'({red_s_ff, DC_FRAC'(0)});
            end
            OP_UPD_IR:  dc_ir_ff  <= upd_sum[DC_FRAC +: DC_W];
            OP_UPD_RED: dc_red_ff <= upd_sum[DC_FRAC +: DC_W];
            OP_TAKE_BPM: begin
               hist_ff[hist_pos_ff] <= bpm_sat;
               if (hist_pos_ff == HIST_IDX_W'(HISTORY_DEPTH - 1)) begin
                  hist_pos_ff <= '0;
               end else begin
                  hist_pos_ff <= hist_pos_ff + HIST_IDX_W'(1);
               end
            end
            OP_TAKE_HR:  held_hr_ff    <= div_q[HR_W-1:0];
            OP_SP_ZERO:  held_spo2_ff  <= '0;
            OP_TAKE_SP:  held_spo2_ff  <= sp_take;
            OP_VALID:    held_valid_ff <= hcnt_ff >= HIST_CNT_W'(2);
            OP_FINISH: begin
               if (is_peak_ff) begin
                  peak_level_ff <= prev_ff;
                  last_tick_ff  <= now_ff;
                  peak_seen_ff  <= 1'b1;
                  rising_ff     <= 1'b0;
               end
               if (is_trough_ff) begin
                  valley_level_ff <= prev_ff;
                  rising_ff       <= 1'b1;
               end
               prev2_ff <= prev_ff;
               prev_ff  <= ir_s_ff;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         ir_ff  <= req_ir_sample;
         red_ff <= req_red_sample;
         now_ff <= req_tick_now;
      end
      case (cmd.op) inside
         OP_SUM: begin
            ir_sum_ff  <= ir_sum_in;
            red_sum_ff <= red_sum_in;
            win_cnt_ff <= win_cnt_in;
         end
         OP_TAKE_IR:  ir_s_ff  <= div_q[SAMPLE_W-1:0];
         OP_TAKE_RED: red_s_ff <= div_q[SAMPLE_W-1:0];
         OP_MUL_IR_OLD, OP_UPD_IR, OP_IVL: prod_ff <= prod_in;
         OP_MUL_IR_NEW, OP_MUL_RED_NEW: begin
            acc_ff  <= ACC_W'(prod_ff) + DC_ROUND;
            prod_ff <= prod_in;
         end
         OP_DETECT: begin
            is_peak_ff   <= det_en && is_peak && rising_ff;
            is_trough_ff <= det_en && is_trough;
            beat_ff      <= det_en && is_peak && rising_ff && amp_ok && peak_seen_ff;
         end
         OP_HSUM: begin
            hsum_ff <= hsum_in;
            hcnt_ff <= hcnt_in;
         end
         OP_SPMUL: begin
            num_ff <= (SP_W'(dc_ir_ff) << 4) + (SP_W'(dc_ir_ff) << 2);
            lim_ff <= (SP_W'(dc_red_ff) << 5) - (SP_W'(dc_red_ff) << 1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.op == OP_PUBLISH) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == OP_PUBLISH) begin
         rsp_hr_ff   <= held_hr_ff;
         rsp_spo2_ff <= held_spo2_ff;
         rsp_rv_ff   <= held_valid_ff;
         if (!finger_ff) begin
            rsp_status_ff <= STATUS_IDLE;
         end else if (held_valid_ff) begin
            rsp_status_ff <= STATUS_DONE;
         end else begin
            rsp_status_ff <= STATUS_SAMPLING;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_heart_rate    = rsp_hr_ff;
   assign rsp_spo2_percent  = rsp_spo2_ff;
   assign rsp_reading_valid = rsp_rv_ff;
   assign rsp_status        = rsp_status_ff;

   assign stat.below_thr = ir_ff < cfg.presence;
   assign stat.div_busy  = div_busy;
   assign stat.dc_zero   = dc_ir_ff == '0;
   assign stat.beat      = beat_ff;
   assign stat.ivl_ok    = (prod_ff > PROD_W'(cfg.min_ivl))
                           && (prod_ff < PROD_W'(cfg.max_ivl));
   assign stat.hist_ok   = hcnt_ff >= HIST_CNT_W'(2);
   assign stat.spo2_en   = (dc_ir_ff != '0) && (dc_red_ff != '0)
                           && (peak_level_ff > valley_level_ff);
   assign stat.spo2_over = num_ff > lim_ff;
   assign stat.rsp_free  = !rsp_valid_ff || rsp_ready;

   a_publish_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |-> !rsp_valid_ff)
      else $error("result overwritten before transfer");

endmodule

// ----- rtl/core/ppgest_ctrl.sv -----
// Controller: sequences the datapath through one sample per transfer.
// Depends on ppgest_pkg for the command and status structs.
module ppgest_ctrl import ppgest_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   typedef enum logic [5:0] {
      S_IDLE, S_CHECK, S_CLEAR, S_WRITE, S_SUM, S_DIV_IR, S_WAIT_IR, S_TAKE_IR,
      S_DIV_RED, S_WAIT_RED, S_TAKE_RED, S_DC, S_SEED, S_M1, S_M2, S_M3, S_M4,
      S_M5, S_DETECT, S_BEAT, S_IVL, S_IVL_CHK, S_DIV_BPM, S_WAIT_BPM,
      S_TAKE_BPM, S_HSUM, S_HIST_CHK, S_DIV_HR, S_WAIT_HR, S_TAKE_HR, S_SPO2,
      S_SPMUL, S_SP_CHK, S_SP_ZERO, S_DIV_SP, S_WAIT_SP, S_TAKE_SP, S_VALID,
      S_FINISH, S_OUT, S_PUB
   } state_type;

   state_type state_ff, state_in;
   op_type    op_ff, op_in;

   // the op registered with a state runs only as that state is entered, not while it is held
   always_comb begin
      state_in = state_ff;
      op_in    = OP_NONE;
      unique case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_CHECK;
         S_CHECK: begin
            if (stat.below_thr) begin
               state_in = S_CLEAR;
               op_in    = OP_CLEAR;
            end else begin
               state_in = S_WRITE;
               op_in    = OP_WRITE;
            end
         end
         S_CLEAR:    state_in = S_OUT;
         S_WRITE:    begin state_in = S_SUM;     op_in = OP_SUM;     end
         S_SUM:      begin state_in = S_DIV_IR;  op_in = OP_DIV_IR;  end
         S_DIV_IR:   state_in = S_WAIT_IR;
         S_WAIT_IR:  if (!stat.div_busy) begin state_in = S_TAKE_IR; op_in = OP_TAKE_IR; end
         S_TAKE_IR:  begin state_in = S_DIV_RED; op_in = OP_DIV_RED; end
         S_DIV_RED:  state_in = S_WAIT_RED;
         S_WAIT_RED: if (!stat.div_busy) begin state_in = S_TAKE_RED; op_in = OP_TAKE_RED; end
         S_TAKE_RED: state_in = S_DC;
         S_DC: begin
            if (stat.dc_zero) begin
               state_in = S_SEED;
               op_in    = OP_SEED;
            end else begin
               state_in = S_M1;
               op_in    = OP_MUL_IR_OLD;
            end
         end
         S_SEED:     begin state_in = S_DETECT;  op_in = OP_DETECT;      end
         S_M1:       begin state_in = S_M2;      op_in = OP_MUL_IR_NEW;  end
         S_M2:       begin state_in = S_M3;      op_in = OP_UPD_IR;      end
         S_M3:       begin state_in = S_M4;      op_in = OP_MUL_RED_NEW; end
         S_M4:       begin state_in = S_M5;      op_in = OP_UPD_RED;     end
         S_M5:       begin state_in = S_DETECT;  op_in = OP_DETECT;      end
         S_DETECT:   state_in = S_BEAT;
         S_BEAT: begin
            if (stat.beat) begin
               state_in = S_IVL;
               op_in    = OP_IVL;
            end else begin
               state_in = S_FINISH;
               op_in    = OP_FINISH;
            end
         end
         S_IVL:      state_in = S_IVL_CHK;
         S_IVL_CHK: begin
            if (stat.ivl_ok) begin
               state_in = S_DIV_BPM;
               op_in    = OP_DIV_BPM;
            end else begin
               state_in = S_FINISH;
               op_in    = OP_FINISH;
            end
         end
         S_DIV_BPM:  state_in = S_WAIT_BPM;
         S_WAIT_BPM: if (!stat.div_busy) begin state_in = S_TAKE_BPM; op_in = OP_TAKE_BPM; end
         S_TAKE_BPM: begin state_in = S_HSUM; op_in = OP_HSUM; end
         S_HSUM:     state_in = S_HIST_CHK;
         S_HIST_CHK: begin
            if (stat.hist_ok) begin
               state_in = S_DIV_HR;
               op_in    = OP_DIV_HR;
            end else begin
               state_in = S_SPO2;
            end
         end
         S_DIV_HR:   state_in = S_WAIT_HR;
         S_WAIT_HR:  if (!stat.div_busy) begin state_in = S_TAKE_HR; op_in = OP_TAKE_HR; end
         S_TAKE_HR:  state_in = S_SPO2;
         S_SPO2: begin
            if (stat.spo2_en) begin
               state_in = S_SPMUL;
               op_in    = OP_SPMUL;
            end else begin
               state_in = S_VALID;
               op_in    = OP_VALID;
            end
         end
         S_SPMUL:    state_in = S_SP_CHK;
         S_SP_CHK: begin
            if (stat.spo2_over) begin
               state_in = S_SP_ZERO;
               op_in    = OP_SP_ZERO;
            end else begin
               state_in = S_DIV_SP;
               op_in    = OP_DIV_SP;
            end
         end
         S_SP_ZERO:  begin state_in = S_VALID; op_in = OP_VALID; end
         S_DIV_SP:   state_in = S_WAIT_SP;
         S_WAIT_SP:  if (!stat.div_busy) begin state_in = S_TAKE_SP; op_in = OP_TAKE_SP; end
         S_TAKE_SP:  begin state_in = S_VALID;  op_in = OP_VALID;  end
         S_VALID:    begin state_in = S_FINISH; op_in = OP_FINISH; end
         S_FINISH:   state_in = S_OUT;
         S_OUT:      if (stat.rsp_free) begin state_in = S_PUB; op_in = OP_PUBLISH; end
         S_PUB:      state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         op_ff    <= OP_NONE;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign cmd.op    = op_ff;

   a_accept_check: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_CHECK && op_ff == OP_NONE))
      else $error("transfer accepted without sample check");

endmodule

// ----- sim/tb_pulse_oximeter_hr_spo2_estimator_unit.sv -----
// Self-checking bench for the heart-rate and SpO2 estimator: directed table, then
// synthetic pulse waveforms and noise, checked against an in-bench predictor.
// Depends on ppgest_pkg and pulse_oximeter_hr_spo2_estimator_unit.
module tb_pulse_oximeter_hr_spo2_estimator_unit;
   import ppgest_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 300;

   typedef struct packed {
      logic [HR_W-1:0]     hr;
      logic [SPO2_W-1:0]   spo2;
      logic                rv;
      logic [STATUS_W-1:0] st;
   } reading_type;

   typedef struct {
      logic [SAMPLE_W-1:0] ir;
      logic [SAMPLE_W-1:0] red;
      logic [TICK_W-1:0]   tick;
      bit                  fixed;
      reading_type         want;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_ready = 0, csr_valid = 0;
   logic [SAMPLE_W-1:0] req_ir_sample = 0, req_red_sample = 0;
   logic [TICK_W-1:0] req_tick_now = 0;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;
   logic req_ready, rsp_valid, csr_ready, rsp_reading_valid;
   logic [HR_W-1:0] rsp_heart_rate;
   logic [SPO2_W-1:0] rsp_spo2_percent;
   logic [STATUS_W-1:0] rsp_status;

   pulse_oximeter_hr_spo2_estimator_unit DUT (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   logic [SAMPLE_W-1:0] p_thr, p_minh;
   logic [ALPHA_W-1:0] p_alpha;
   logic [PERIOD_W-1:0] p_tms;
   logic [IVL_W-1:0] p_minivl, p_maxivl;
   logic [SAMPLE_W-1:0] ir_win [SMOOTH_WINDOW];
   logic [SAMPLE_W-1:0] red_win [SMOOTH_WINDOW];
   int unsigned wpos, hpos;
   bit wfull, pk_seen, rising, h_valid;
   logic [SAMPLE_W-1:0] sm1, sm2, pk_lvl, vl_lvl;
   logic [63:0] dc_ir, dc_red;
   logic [31:0] last_tick;
   logic [7:0] rate_hist [HISTORY_DEPTH];
   logic [7:0] h_hr;
   logic [6:0] h_spo2;

   reading_type expected_readings[$];
   int mismatches = 0, n_items = 0, n_readings = 0, n_beats = 0, idle_cnt = 0;
   int send_idle = 0, recv_stall = 0;

   function automatic void clear_estimate();
      for (int i = 0; i < SMOOTH_WINDOW; i++) begin
         ir_win[i] = 0;
         red_win[i] = 0;
      end
      for (int i = 0; i < HISTORY_DEPTH; i++) rate_hist[i] = 0;
      wpos = 0; hpos = 0; wfull = 0; pk_seen = 0; rising = 0; h_valid = 0;
      sm1 = 0; sm2 = 0; pk_lvl = 0; vl_lvl = 0; dc_ir = 0; dc_red = 0;
      last_tick = 0; h_hr = 0; h_spo2 = 0;
   endfunction

   function automatic logic [63:0] dc_next(logic [63:0] avg, logic [SAMPLE_W-1:0] s);
      logic [63:0] a, acc;
      a = 64'(p_alpha);
      acc = a * avg + (64'd65536 - a) * ({46'd0, s} << 16) + 64'd32768;
      return (acc >> 16) & 64'h3_FFFF_FFFF;
   endfunction

   function automatic reading_type predict_reading(logic [SAMPLE_W-1:0] ir,
                                                   logic [SAMPLE_W-1:0] red,
                                                   logic [TICK_W-1:0] tnow);
      reading_type r;
      logic [63:0] si, sr, ivl, bpm, num, c;
      logic [SAMPLE_W-1:0] ir_s, red_s, amp;
      int unsigned cnt, hsum;
      bit is_pk, is_vl;
      if (ir < p_thr) begin
         clear_estimate();
         return '0;
      end
      ir_win[wpos] = ir;
      red_win[wpos] = red;
      cnt = wfull ? SMOOTH_WINDOW : wpos + 1;
      si = 0; sr = 0;
      for (int i = 0; i < cnt; i++) begin
         si += ir_win[i];
         sr += red_win[i];
      end
      ir_s = SAMPLE_W'(si / cnt);
      red_s = SAMPLE_W'(sr / cnt);
      wpos++;
      if (wpos >= SMOOTH_WINDOW) begin
         wpos = 0;
         wfull = 1;
      end
      if (dc_ir == 0) begin
         dc_ir = {46'd0, ir_s} << 16;
         dc_red = {46'd0, red_s} << 16;
      end else begin
         dc_ir = dc_next(dc_ir, ir_s);
         dc_red = dc_next(dc_red, red_s);
      end
      if (wfull && sm2 > 0) begin
         is_pk = sm1 > sm2 && sm1 > ir_s;
         is_vl = sm1 < sm2 && sm1 < ir_s;
         if (is_pk && rising) begin
            amp = sm1 > vl_lvl ? sm1 - vl_lvl : 0;
            if (amp > p_minh && pk_seen) begin
               // tick difference wraps at 32 bits before scaling
               ivl = 64'(32'(tnow - last_tick)) * 64'(p_tms);
               if (ivl > p_minivl && ivl < p_maxivl) begin
                  n_beats++;
                  bpm = 64'd60000 / ivl;
                  if (bpm > 255) bpm = 255;
                  rate_hist[hpos] = bpm[7:0];
                  hpos = (hpos + 1) % HISTORY_DEPTH;
                  hsum = 0; cnt = 0;
                  for (int i = 0; i < HISTORY_DEPTH; i++)
                     if (rate_hist[i] != 0) begin
                        hsum += rate_hist[i];
                        cnt++;
                     end
                  if (cnt >= 2) h_hr = 8'(hsum / cnt);
                  if (dc_ir > 0 && dc_red > 0 && pk_lvl > vl_lvl) begin
                     num = 20 * dc_ir;
                     if (num > 30 * dc_red) h_spo2 = 0;
                     else begin
                        c = (num + dc_red - 1) / dc_red;
                        h_spo2 = (c <= 10) ? 7'd100 : 7'(110 - c);
                     end
                  end
                  h_valid = cnt >= 2;
               end
            end
            pk_lvl = sm1;
            last_tick = tnow;
            pk_seen = 1;
            rising = 0;
         end
         if (is_vl) begin
            vl_lvl = sm1;
            rising = 1;
         end
      end
      sm2 = sm1;
      sm1 = ir_s;
      r.hr = h_hr;
      r.spo2 = h_spo2;
      r.rv = h_valid;
      r.st = h_valid ? STATUS_DONE : STATUS_SAMPLING;
      return r;
   endfunction

   // the caller drops csr_valid after the last write of a group
   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_PRESENCE:   p_thr = val;
         CSR_MIN_HEIGHT: p_minh = val;
         CSR_ALPHA:      p_alpha = val[ALPHA_W-1:0];
         CSR_TICK_MS:    p_tms = val[PERIOD_W-1:0];
         CSR_MIN_IVL:    p_minivl = val[IVL_W-1:0];
         CSR_MAX_IVL:    p_maxivl = val[IVL_W-1:0];
         default: ;
      endcase
   endtask

   // valid stays high after a transfer; the next item or drain() decides what follows
   task automatic send_sample(logic [SAMPLE_W-1:0] ir, logic [SAMPLE_W-1:0] red,
                              logic [TICK_W-1:0] tnow, bit fixed, reading_type want);
      reading_type r;
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_ir_sample <= ir;
      req_red_sample <= red;
      req_tick_now <= tnow;
      do @(posedge clock); while (!req_ready);
      r = predict_reading(ir, red, tnow);
      expected_readings.push_back(fixed ? want : r);
      n_items++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // one phase of pulses: sinusoid-like triangle with random period, noise and dropouts
   task automatic pulse_phase(int count);
      int per, ph, amp, base, rbase;
      logic [TICK_W-1:0] t;
      t = $urandom;
      per = $urandom_range(6, 40);
      amp = $urandom_range(50, 20000);
      base = $urandom_range(12000, 200000);
      rbase = $urandom_range(10000, 240000);
      ph = 0;
      for (int i = 0; i < count; i++) begin
         int v, k;
         k = ph % per;
         v = (k < per / 2) ? k : per - k;
         v = base + v * amp / (per / 2) + $urandom_range(0, 30);
         if ($urandom_range(99) < 2) v = $urandom_range(0, 262143);
         if (v > 262143) v = 262143;
         if ($urandom_range(199) == 0) per = $urandom_range(6, 40);
         t += $urandom_range(15, 60);
         send_sample(SAMPLE_W'(v), SAMPLE_W'(rbase + v / 8 % 20000), t, 0, '0);
         ph++;
      end
   endtask

   always @(posedge clock) begin
      reading_type got, want;
      rsp_ready <= (recv_stall == 0) || ($urandom_range(99) >= recv_stall);
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_heart_rate, rsp_spo2_percent, rsp_reading_valid, rsp_status};
         n_readings++;
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected reading %p", got);
         end else begin
            want = expected_readings.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch: want %p got %p", want, got);
            end
         end
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || reset)
         idle_cnt <= 0;
      else if (req_valid || expected_readings.size() != 0 || csr_valid)
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   row_type rows[$];

   initial begin
      row_type rw;
      p_thr = RST_PRESENCE; p_minh = RST_MIN_HEIGHT; p_alpha = RST_ALPHA;
      p_tms = RST_TICK_MS; p_minivl = RST_MIN_IVL; p_maxivl = RST_MAX_IVL;
      clear_estimate();
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: no finger, extremes, then a clean pulse train at reset settings
      rows.push_back('{18'd0, 18'd0, 32'd0, 1'b1, '0});
      rows.push_back('{18'd9999, 18'h3FFFF, 32'hFFFF_FFFF, 1'b1, '0});
      rows.push_back('{18'd10000, 18'd0, 32'd0, 1'b1,
                       '{8'd0, 7'd0, 1'b0, STATUS_SAMPLING}});
      rows.push_back('{18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF, 1'b0, '0});
      rows.push_back('{18'd1, 18'd1, 32'd5, 1'b1, '0});
      for (int i = 0; i < 20; i++) begin
         int k;
         k = i % 6;
         rw = '{SAMPLE_W'(20000 + ((k < 3) ? k : 6 - k) * 3000), 18'd30000,
                TICK_W'(32'hFFFF_FF00 + i * 100), 1'b0, '0};
         rows.push_back(rw);
      end
      foreach (rows[i]) send_sample(rows[i].ir, rows[i].red, rows[i].tick, rows[i].fixed,
                                    rows[i].want);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 76; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 76; end
            default: begin send_idle = 19; recv_stall = 19; end
         endcase
         case (ph)
            0: begin
               write_reg(CSR_PRESENCE, 18'd12000); write_reg(CSR_MIN_HEIGHT, 18'd0);
               write_reg(CSR_ALPHA, 18'd0); write_reg(CSR_TICK_MS, 18'd1);
               write_reg(CSR_MIN_IVL, 18'd1); write_reg(CSR_MAX_IVL, 18'hFFFF);
            end
            1: begin
               write_reg(CSR_ALPHA, 18'hFFFF); write_reg(CSR_TICK_MS, 18'd1000);
               write_reg(CSR_MIN_HEIGHT, 18'h3FFFF); write_reg(CSR_PRESENCE, 18'd0);
            end
            2: begin
               write_reg(CSR_MIN_HEIGHT, 18'd10); write_reg(CSR_TICK_MS, 18'd10);
               write_reg(CSR_MIN_IVL, 18'd100); write_reg(CSR_MAX_IVL, 18'd60000);
               write_reg(CSR_PRESENCE, 18'h3FFFF);
            end
            default: begin
               write_reg(CSR_PRESENCE, CSR_DATA_W'($urandom_range(0, 15000)));
               write_reg(CSR_MIN_HEIGHT, CSR_DATA_W'($urandom_range(0, 500)));
               write_reg(CSR_ALPHA, CSR_DATA_W'($urandom));
               write_reg(CSR_TICK_MS, CSR_DATA_W'($urandom_range(1, 20)));
               write_reg(CSR_MIN_IVL, CSR_DATA_W'($urandom_range(1, 400)));
               write_reg(CSR_MAX_IVL, CSR_DATA_W'($urandom_range(400, 65535)));
            end
         endcase
         csr_valid <= 0;
         pulse_phase(160);
         drain();
      end
      $display("run: %0d samples, %0d readings, %0d scored beats, 8 register settings",
               n_items, n_readings, n_beats);
      if (mismatches == 0 && expected_readings.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
